### hw/rtl/fcbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change bounding box package
// Field widths, configuration register indexes and the pixel format
// conversion shared by the frame change bounding box design.
// ----------------------------------------------------------------------------
package fcbb_pkg;

    // Payload widths
    localparam int PIXEL_IN_W  = 16;
    localparam int PIXEL_OUT_W = 15;
    localparam int BOX_LO_W    = 9;
    localparam int BOX_HI_W    = 10;
    localparam int CFG_W       = 10;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // Both size registers come out of reset at 512.
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd512;

    // RGB565 to BGR555: the lowest green bit is dropped.
    function automatic logic [PIXEL_OUT_W-1:0] to_bgr555(input logic [PIXEL_IN_W-1:0] pix);
        return {pix[4:0], pix[10:6], pix[15:11]};
    endfunction

endpackage

### hw/rtl/fcbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change bounding box generic RAM
// One write port and one read port with registered read data. A read and a
// write of the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module fcbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/frame_change_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change bounding box
// Compares each RGB565 pixel with the same pixel of the previous frame,
// converts it to BGR555 and reports the box of changed pixels per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on i_pixel_valid / o_pixel_ready, one word
//   per accepted handshake. Every pixel gives one result word on
//   o_result_valid / i_result_ready: the BGR555 pixel, a changed flag and,
//   on the last pixel of a frame, the box of changed pixels (right and
//   bottom exclusive) or box_empty when nothing changed.
//   The frame size is set through the configuration write channel
//   (index 0 width, index 1 height) while no pixel is in flight.
//   Path: an accepted pixel goes through the compare stage register and then
//   the output register before it is offered as a result word.
//   Throughput: one pixel per clock while results are taken; the frame store
//   has a read and a write port, each used once per pixel at the accepting edge.
//   Reset: a clearing pass writes zero to every frame store entry, one per
//   cycle, MAX_WIDTH * MAX_HEIGHT entries (262144 at the defaults); no pixel
//   is taken meanwhile. Configuration writes are always taken.
//   Stall: a result waits in the output register; one more pixel can sit in
//   the compare stage, after which o_pixel_ready falls.
// ----------------------------------------------------------------------------
module frame_change_bounding_box #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [0:0]                           i_cfg_index,
    input  logic [fcbb_pkg::CFG_W-1:0]           i_cfg_data,
    // Pixel input channel
    input  logic                                 i_pixel_valid,
    output logic                                 o_pixel_ready,
    input  logic [fcbb_pkg::PIXEL_IN_W-1:0]      i_pixel_rgb565,
    // Result channel
    output logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    output logic [fcbb_pkg::PIXEL_OUT_W-1:0]     o_pixel_bgr555,
    output logic                                 o_pixel_changed,
    output logic                                 o_frame_done,
    output logic                                 o_box_empty,
    output logic [fcbb_pkg::BOX_LO_W-1:0]        o_box_left,
    output logic [fcbb_pkg::BOX_LO_W-1:0]        o_box_top,
    output logic [fcbb_pkg::BOX_HI_W-1:0]        o_box_right,
    output logic [fcbb_pkg::BOX_HI_W-1:0]        o_box_bottom
);

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [fcbb_pkg::CFG_W-1:0] r_frame_width;
    logic [fcbb_pkg::CFG_W-1:0] r_frame_height;

    // Clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Raster position of the next pixel
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [ADDR_W-1:0] r_line_base;

    // Compare stage
    logic                                r_s1_valid;
    logic [fcbb_pkg::PIXEL_IN_W-1:0]     r_s1_pixel;
    logic [CW-1:0]                       r_s1_col;
    logic [RW-1:0]                       r_s1_row;
    logic                                r_s1_frame_end;

    // Box tracking
    logic          r_any;
    logic [CW-1:0] r_min_col;
    logic [CW-1:0] r_max_col;
    logic [RW-1:0] r_min_row;
    logic [RW-1:0] r_max_row;

    // Output register
    logic                                r_out_valid;
    logic [fcbb_pkg::PIXEL_OUT_W-1:0]    r_out_pixel;
    logic                                r_out_changed;
    logic                                r_out_frame_done;
    logic                                r_out_empty;
    logic [fcbb_pkg::BOX_LO_W-1:0]       r_out_left;
    logic [fcbb_pkg::BOX_LO_W-1:0]       r_out_top;
    logic [fcbb_pkg::BOX_HI_W-1:0]       r_out_right;
    logic [fcbb_pkg::BOX_HI_W-1:0]       r_out_bottom;

    // Handshake and datapath signals
    logic                            out_free;
    logic                            s1_adv;
    logic                            in_fire;
    logic [CW:0]                     width_eff;
    logic [RW:0]                     height_eff;
    logic                            line_end;
    logic                            frame_end;
    logic [ADDR_W-1:0]               pix_addr;
    logic                            ram_wr_en;
    logic [ADDR_W-1:0]               ram_wr_addr;
    logic [fcbb_pkg::PIXEL_IN_W-1:0] ram_wr_data;
    logic [fcbb_pkg::PIXEL_IN_W-1:0] prev_pixel;
    logic                            changed;
    logic                            n_any;
    logic [CW-1:0]                   n_min_col;
    logic [CW-1:0]                   n_max_col;
    logic [RW-1:0]                   n_min_row;
    logic [RW-1:0]                   n_max_row;
    logic [CW:0]                     right_sum;
    logic [RW:0]                     bottom_sum;

    // Flow control: the output register parts the two sides.
    assign out_free      = !r_out_valid || i_result_ready;
    assign s1_adv        = r_s1_valid && out_free;
    assign o_pixel_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_fire       = i_pixel_valid && o_pixel_ready;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fcbb_pkg::CFG_SIZE_RESET;
            r_frame_height <= fcbb_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fcbb_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                fcbb_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes in force: zero acts as one, oversize is clipped to the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = (CW+1)'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            width_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            width_eff = (CW+1)'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            height_eff = (RW+1)'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            height_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            height_eff = (RW+1)'(r_frame_height);
        end
    end

    assign line_end  = ({1'b0, r_col} + (CW+1)'(1)) >= width_eff;
    assign frame_end = line_end && (({1'b0, r_row} + (RW+1)'(1)) >= height_eff);
    assign pix_addr  = r_line_base + ADDR_W'(r_col);

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Raster position, advanced on every accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_line_base <= '0;
        end else if (in_fire) begin
            if (frame_end) begin
                r_col       <= '0;
                r_row       <= '0;
                r_line_base <= '0;
            end else if (line_end) begin
                r_col       <= '0;
                r_row       <= r_row + RW'(1);
                r_line_base <= r_line_base + ADDR_W'(MAX_WIDTH);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Frame store: the stored pixel is read and replaced at the accepting edge.
    assign ram_wr_en   = r_clr_busy || in_fire;
    assign ram_wr_addr = r_clr_busy ? r_clr_addr : pix_addr;
    assign ram_wr_data = r_clr_busy ? '0 : i_pixel_rgb565;

    fcbb_ram #(
        .WIDTH (fcbb_pkg::PIXEL_IN_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (pix_addr),
        .o_rd_data (prev_pixel)
    );

    // Compare stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixel     <= i_pixel_rgb565;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_s1_frame_end <= frame_end;
        end
    end

    // Change detection and box update for the pixel in the compare stage.
    assign changed = prev_pixel != r_s1_pixel;

    always_comb begin
        n_any     = r_any;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (changed) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_min_col = r_s1_col;
                n_max_col = r_s1_col;
                n_min_row = r_s1_row;
                n_max_row = r_s1_row;
            end else begin
                if (r_s1_col < r_min_col) n_min_col = r_s1_col;
                if (r_s1_col > r_max_col) n_max_col = r_s1_col;
                if (r_s1_row < r_min_row) n_min_row = r_s1_row;
                if (r_s1_row > r_max_row) n_max_row = r_s1_row;
            end
        end
    end

    assign right_sum  = {1'b0, n_max_col} + (CW+1)'(1);
    assign bottom_sum = {1'b0, n_max_row} + (RW+1)'(1);

    // Box tracking registers, cleared after the last pixel of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any     <= 1'b0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
        end else if (s1_adv) begin
            if (r_s1_frame_end) begin
                r_any     <= 1'b0;
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
            end else begin
                r_any     <= n_any;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel      <= fcbb_pkg::to_bgr555(r_s1_pixel);
            r_out_changed    <= changed;
            r_out_frame_done <= r_s1_frame_end;
            r_out_empty      <= r_s1_frame_end && !n_any;
            if (r_s1_frame_end && n_any) begin
                r_out_left   <= fcbb_pkg::BOX_LO_W'(n_min_col);
                r_out_top    <= fcbb_pkg::BOX_LO_W'(n_min_row);
                r_out_right  <= fcbb_pkg::BOX_HI_W'(right_sum);
                r_out_bottom <= fcbb_pkg::BOX_HI_W'(bottom_sum);
            end else begin
                r_out_left   <= '0;
                r_out_top    <= '0;
                r_out_right  <= '0;
                r_out_bottom <= '0;
            end
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_pixel_bgr555  = r_out_pixel;
    assign o_pixel_changed = r_out_changed;
    assign o_frame_done    = r_out_frame_done;
    assign o_box_empty     = r_out_empty;
    assign o_box_left      = r_out_left;
    assign o_box_top       = r_out_top;
    assign o_box_right     = r_out_right;
    assign o_box_bottom    = r_out_bottom;

    // The line base always matches the row count.
    a_line_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_line_base) == 32'(r_row) * MAX_WIDTH)
        else $error("line base out of step with row count");

    // The position never leaves the frame store.
    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < MAX_WIDTH) && (32'(r_row) < MAX_HEIGHT))
        else $error("raster position beyond maximum frame size");

    // Once a change is recorded the box is well formed.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min_col <= r_max_col) && (r_min_row <= r_max_row))
        else $error("box minimum above maximum");

    // The clearing pass ends only after the last entry.
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == ADDR_W'(DEPTH - 1))
        else $error("clearing pass ended early");

    // Box fields stay zero on words that do not close a frame.
    a_box_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_frame_done) |->
            !r_out_empty && (r_out_left == '0) && (r_out_top == '0) &&
            (r_out_right == '0) && (r_out_bottom == '0))
        else $error("box fields set outside frame end");

endmodule
